// ===== rtl/core/ivba_pkg.sv =====
// Package for the interrupt vector bitmap allocator.
// Holds command, status and register index codes and reset constants.
// No dependencies; used by the top level and by the checker.
package ivba_pkg;

    localparam int VECTORS_DEFAULT = 256;

    // Command codes carried in the cmd field
    localparam logic [2:0] CMD_ALLOCATE  = 3'd0;
    localparam logic [2:0] CMD_RESERVE   = 3'd1;
    localparam logic [2:0] CMD_RELEASE   = 3'd2;
    localparam logic [2:0] CMD_CLEAR_ALL = 3'd3;
    localparam logic [2:0] CMD_MARK      = 3'd4;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_NO_ROOM   = 2'd2;
    localparam logic [1:0] ST_PROTECTED = 2'd3;

    // Configuration register indexes
    localparam logic [7:0] CFG_RESERVED_LOW = 8'd0;
    localparam logic [7:0] CFG_SCI_VECTOR   = 8'd1;
    localparam logic [7:0] CFG_SCI_ENABLE   = 8'd2;

    // Register reset values and fixed vectors
    localparam logic [7:0] RESERVED_LOW_RESET = 8'h20;
    localparam logic [7:0] SCI_VECTOR_RESET   = 8'h00;
    localparam logic       SCI_ENABLE_RESET   = 1'b0;
    localparam logic [7:0] LOW_PROTECT        = 8'h20;
    localparam logic [7:0] SPURIOUS_VECTOR    = 8'hFF;

endpackage

// ===== rtl/core/ivba_map.sv =====
// Occupancy map storage: one bit per vector, one write and one read a cycle.
// The read data is registered. Depends on nothing else.
module ivba_map #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic          wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic          rd_data
);

    logic mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/core/interrupt_vector_bitmap_allocator.sv =====
// Interrupt vector bitmap allocator, top level.
// Uses ivba_pkg and the map storage in ivba_map.
//
// Commands arrive on the s_axis channel, one transaction each, and every
// command gives exactly one result transaction on the m_axis channel. The
// cfg channel writes the three registers; it is always ready and a new
// setting reaches the map at the next clear-all.
// The map is scanned one bit per cycle through its single read port.
// Allocate scans the window for a free run of count vectors, then marks it;
// mark range writes every vector of the range that lies in the map; clear-all
// rewrites the whole map (DEPTH is VECTORS capped at 256); reserve and
// release write one bit, and rejected commands write nothing.
// One command is worked on at a time: s_axis_tready is high only while the
// block is idle. A finished result sits in the output register; if the
// receiver stalls, the block still takes the next command and holds that
// command's result until the output register frees.
// After reset the map is rebuilt from the reset register values by a pass
// over every map address, during which no command is accepted.
module interrupt_vector_bitmap_allocator #(
    parameter int VECTORS = ivba_pkg::VECTORS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // cmd[2:0], first_vector[10:3],
                                        // last_vector[18:11], count[27:19], zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // status[1:0], start_vector[9:2], zero
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_addr,
    input  logic [7:0]  cfg_data
);

    // Vectors above 255 can never be addressed by the 8-bit fields.
    localparam int DEPTH = (VECTORS < 256) ? VECTORS : 256;
    localparam int AW = $clog2(DEPTH);
    localparam logic [AW-1:0] ADDR_MAX = AW'(DEPTH - 1);
    localparam bit HAS_SPURIOUS = (VECTORS > 255);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_SCAN    = 5'b00010,
        S_FILL    = 5'b00100,
        S_REBUILD = 5'b01000,
        S_DONE    = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic          init_reg, init_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          more_reg, more_next;
    logic [AW-1:0] prev_addr_reg, prev_addr_next;
    logic          prev_vld_reg, prev_vld_next;
    logic [AW-1:0] lst_reg, lst_next;
    logic [8:0]    cnt_reg, cnt_next;
    logic [8:0]    run_reg, run_next;
    logic [AW-1:0] fill_addr_reg, fill_addr_next;
    logic [AW-1:0] fill_end_reg, fill_end_next;
    logic [1:0]    res_status_reg, res_status_next;
    logic [7:0]    res_start_reg, res_start_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    out_status_reg, out_status_next;
    logic [7:0]    out_start_reg, out_start_next;

    logic [7:0] reserved_low_reg;
    logic [7:0] sci_vector_reg;
    logic       sci_enable_reg;

    logic [2:0] in_cmd;
    logic [7:0] in_first;
    logic [7:0] in_last;
    logic [8:0] in_count;

    logic          in_accept;
    logic          first_in_map;
    logic [AW-1:0] last_clip;
    logic          is_protected;
    logic [8:0]    scan_run;
    logic [8:0]    scan_start;
    logic [7:0]    rb_low;
    logic [7:0]    rb_sci_vector;
    logic          rb_sci_enable;
    logic          rb_bit;

    logic          mem_wr_en;
    logic [AW-1:0] mem_wr_addr;
    logic          mem_wr_data;
    logic          mem_rd_data;

    assign in_cmd   = s_axis_tdata[2:0];
    assign in_first = s_axis_tdata[10:3];
    assign in_last  = s_axis_tdata[18:11];
    assign in_count = s_axis_tdata[27:19];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_start_reg, out_status_reg};

    assign first_in_map = (32'(in_first) < VECTORS);
    assign last_clip    = (32'(in_last) >= VECTORS) ? ADDR_MAX : in_last[AW-1:0];
    assign is_protected = (in_first < ivba_pkg::LOW_PROTECT)
                       || (in_first == ivba_pkg::SPURIOUS_VECTOR)
                       || (sci_enable_reg && (in_first == sci_vector_reg));

    // One step of the free-run counter on the bit that has just been read.
    assign scan_run   = mem_rd_data ? 9'd0 : (run_reg + 9'd1);
    assign scan_start = 9'(prev_addr_reg) + 9'd1 - cnt_reg;

    // The pass after reset uses the reset settings, not the live registers.
    assign rb_low        = init_reg ? ivba_pkg::RESERVED_LOW_RESET : reserved_low_reg;
    assign rb_sci_vector = init_reg ? ivba_pkg::SCI_VECTOR_RESET : sci_vector_reg;
    assign rb_sci_enable = init_reg ? ivba_pkg::SCI_ENABLE_RESET : sci_enable_reg;
    assign rb_bit = (9'(fill_addr_reg) < 9'(rb_low))
                 || (HAS_SPURIOUS && (9'(fill_addr_reg) == 9'(ivba_pkg::SPURIOUS_VECTOR)))
                 || (rb_sci_enable && (9'(fill_addr_reg) == 9'(rb_sci_vector)));

    always_comb
    begin
        state_next      = state_reg;
        init_next       = init_reg;
        addr_next       = addr_reg;
        more_next       = more_reg;
        prev_addr_next  = prev_addr_reg;
        prev_vld_next   = 1'b0;
        lst_next        = lst_reg;
        cnt_next        = cnt_reg;
        run_next        = run_reg;
        fill_addr_next  = fill_addr_reg;
        fill_end_next   = fill_end_reg;
        res_status_next = res_status_reg;
        res_start_next  = res_start_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = fill_addr_reg;
        mem_wr_data     = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    res_start_next = 8'd0;
                    state_next     = S_DONE;
                    unique case (in_cmd)
                        ivba_pkg::CMD_ALLOCATE:
                        begin
                            if (in_count == 9'd0)
                            begin
                                res_status_next = ivba_pkg::ST_INVALID;
                            end
                            else if (!first_in_map || (9'(in_first) > 9'(last_clip)))
                            begin
                                res_status_next = ivba_pkg::ST_NO_ROOM;
                            end
                            else
                            begin
                                addr_next  = in_first[AW-1:0];
                                more_next  = 1'b1;
                                lst_next   = last_clip;
                                cnt_next   = in_count;
                                run_next   = 9'd0;
                                state_next = S_SCAN;
                            end
                        end
                        ivba_pkg::CMD_RESERVE, ivba_pkg::CMD_RELEASE:
                        begin
                            if (!first_in_map)
                            begin
                                res_status_next = ivba_pkg::ST_INVALID;
                            end
                            else if (is_protected)
                            begin
                                res_status_next = ivba_pkg::ST_PROTECTED;
                            end
                            else
                            begin
                                mem_wr_en       = 1'b1;
                                mem_wr_addr     = in_first[AW-1:0];
                                mem_wr_data     = (in_cmd == ivba_pkg::CMD_RESERVE);
                                res_status_next = ivba_pkg::ST_OK;
                            end
                        end
                        ivba_pkg::CMD_CLEAR_ALL:
                        begin
                            fill_addr_next  = '0;
                            fill_end_next   = ADDR_MAX;
                            res_status_next = ivba_pkg::ST_OK;
                            state_next      = S_REBUILD;
                        end
                        ivba_pkg::CMD_MARK:
                        begin
                            if (!first_in_map || (in_first > in_last))
                            begin
                                res_status_next = ivba_pkg::ST_INVALID;
                            end
                            else
                            begin
                                fill_addr_next  = in_first[AW-1:0];
                                fill_end_next   = last_clip;
                                res_status_next = ivba_pkg::ST_OK;
                                state_next      = S_FILL;
                            end
                        end
                        default:
                        begin
                            res_status_next = ivba_pkg::ST_INVALID;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                // Issue the next read while the previous bit is examined.
                prev_addr_next = addr_reg;
                prev_vld_next  = more_reg;
                more_next      = more_reg && (addr_reg != lst_reg);
                if (more_reg)
                begin
                    addr_next = addr_reg + AW'(1);
                end
                if (prev_vld_reg)
                begin
                    run_next = scan_run;
                    if (scan_run == cnt_reg)
                    begin
                        fill_addr_next  = scan_start[AW-1:0];
                        fill_end_next   = prev_addr_reg;
                        res_status_next = ivba_pkg::ST_OK;
                        res_start_next  = 8'(scan_start[AW-1:0]);
                        prev_vld_next   = 1'b0;
                        state_next      = S_FILL;
                    end
                    else if (prev_addr_reg == lst_reg)
                    begin
                        res_status_next = ivba_pkg::ST_NO_ROOM;
                        prev_vld_next   = 1'b0;
                        state_next      = S_DONE;
                    end
                end
            end
            S_FILL:
            begin
                mem_wr_en      = 1'b1;
                fill_addr_next = fill_addr_reg + AW'(1);
                if (fill_addr_reg == fill_end_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_REBUILD:
            begin
                mem_wr_en      = 1'b1;
                mem_wr_data    = rb_bit;
                fill_addr_next = fill_addr_reg + AW'(1);
                if (fill_addr_reg == fill_end_reg)
                begin
                    init_next  = 1'b0;
                    state_next = init_reg ? S_IDLE : S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_start_next  = out_start_reg;
        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if ((state_reg == S_DONE) && (!out_valid_reg || m_axis_tready))
        begin
            out_valid_next  = 1'b1;
            out_status_next = res_status_reg;
            out_start_next  = res_start_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_REBUILD;
            init_reg      <= 1'b1;
            fill_addr_reg <= '0;
            fill_end_reg  <= ADDR_MAX;
            more_reg      <= 1'b0;
            prev_vld_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            fill_addr_reg <= fill_addr_next;
            fill_end_reg  <= fill_end_next;
            more_reg      <= more_next;
            prev_vld_reg  <= prev_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        prev_addr_reg  <= prev_addr_next;
        lst_reg        <= lst_next;
        cnt_reg        <= cnt_next;
        run_reg        <= run_next;
        res_status_reg <= res_status_next;
        res_start_reg  <= res_start_next;
        out_status_reg <= out_status_next;
        out_start_reg  <= out_start_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reserved_low_reg <= ivba_pkg::RESERVED_LOW_RESET;
            sci_vector_reg   <= ivba_pkg::SCI_VECTOR_RESET;
            sci_enable_reg   <= ivba_pkg::SCI_ENABLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_addr == ivba_pkg::CFG_RESERVED_LOW)
            begin
                reserved_low_reg <= cfg_data;
            end
            if (cfg_addr == ivba_pkg::CFG_SCI_VECTOR)
            begin
                sci_vector_reg <= cfg_data;
            end
            if (cfg_addr == ivba_pkg::CFG_SCI_ENABLE)
            begin
                sci_enable_reg <= cfg_data[0];
            end
        end
    end

    ivba_map #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_map (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (addr_reg),
        .rd_data (mem_rd_data)
    );

endmodule

// ===== rtl/core/ivba_checker.sv =====
// Port-level checks for the interrupt vector bitmap allocator.
// Uses ivba_pkg; bound to the top level at the end of this file.
module ivba_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata
);

    // A stalled result must hold still.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Commands are worked on one at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("command accepted while busy");

    // Only a successful allocation reports a start vector.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tdata[1:0] != ivba_pkg::ST_OK)
        |-> (m_axis_tdata[9:2] == 8'd0))
        else $error("start vector set on a failed command");

    // The map rebuild after reset keeps commands out.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !s_axis_tready && !m_axis_tvalid)
        else $error("block ready straight after reset");

endmodule

bind interrupt_vector_bitmap_allocator ivba_checker u_ivba_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
